[rtl/core/sdpa_pkg.sv]
// Shared types, sizes and exp tables for the attention block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdpa_pkg;

  localparam int SeqMax      = 32;
  localparam int KeyDimMax   = 16;
  localparam int ValueDimMax = 16;
  localparam int DataWidth   = 16;
  localparam int NumW        = 40;
  localparam int DenW        = 22;

  localparam logic [2:0] CFG_KV_LENGTH = 3'd0;
  localparam logic [2:0] CFG_KEY_DIM   = 3'd1;
  localparam logic [2:0] CFG_VALUE_DIM = 3'd2;
  localparam logic [2:0] CFG_SCALE     = 3'd3;
  localparam logic [2:0] CFG_MASK_EN   = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_EN = 3'd5;

  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_VALUE = 2'd1;
  localparam logic [1:0] FUNC_MASK  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic KIND_OUT    = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_frac(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/sdpa_if.sv]
// Channel interfaces: input words, result words and register writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sdpa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [4:0]         row;
  logic [3:0]         col;
  logic signed [15:0] in_value;
  modport source (output valid, func, row, col, in_value, input ready);
  modport sink   (input valid, func, row, col, in_value, output ready);
endinterface

interface sdpa_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         query_index;
  logic [4:0]         out_index;
  logic signed [15:0] out_value;
  logic               last;
  modport source (output valid, kind, query_index, out_index, out_value, last, input ready);
  modport sink   (input valid, kind, query_index, out_index, out_value, last, output ready);
endinterface

interface sdpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/scaled_dot_product_attention.sv]
// Top level: single-head attention with one shared multiplier and a sequencer.
// Depends on sdpa_pkg, sdpa_if and sdpa_div.
//
// channel  dir  word
// in_i     in   func, row, col, in_value (loads and query elements)
// out_o    out  kind, query_index, out_index, out_value, last
// cfg_i    in   index, data (register writes, always ready)
//
// Loads and query elements are taken only while the sequencer is idle.
// A final query element starts the sequence: a dot product and a scaled
// score per key, an exp per score, a weight per key when weights are on,
// then each output element; the shared multiplier serves every step and
// the divider each weight and output. Results stall the sequencer while out_o is busy.
// Reset is asynchronous; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module scaled_dot_product_attention
  import sdpa_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  sdpa_in_if.sink    in_i,
  sdpa_out_if.source out_o,
  sdpa_cfg_if.sink   cfg_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DOT_RD, S_DOT_MAC, S_SC_LO, S_SC_HI, S_EXP_D, S_EXP_RR, S_EXP_A,
    S_EXP_P, S_W_DIV, S_W_WAIT, S_W_EMIT, S_O_RD, S_O_MAC, S_O_DIV, S_O_WAIT,
    S_O_EMIT
  } state_e;

  state_e state_q;

  logic [5:0]  kv_len_q;
  logic [4:0]  key_dim_q, val_dim_q;
  logic [15:0] scale_q;
  logic        mask_en_q, w_en_q;

  logic signed [15:0] key_mem [SeqMax*KeyDimMax];
  logic signed [15:0] val_mem [SeqMax*ValueDimMax];
  logic signed [15:0] mask_q  [SeqMax];
  logic signed [15:0] qbuf_q  [KeyDimMax];
  logic signed [26:0] score_q [SeqMax];
  logic [16:0]        e_q     [SeqMax];

  logic [4:0]         j_q, qi_q;
  logic [3:0]         t_q;
  logic signed [15:0] qv_q, kd_q, vd_q;
  logic signed [39:0] acc_q;
  logic [33:0]        lo_q;
  logic signed [26:0] mx_q;
  logic [27:0]        d_q;
  logic [16:0]        p_q, a_q;
  logic [21:0]        den_q;
  logic               neg_q;
  logic [39:0]        quo_q;

  logic        ovalid_q, okind_q, olast_q;
  logic [4:0]  oqi_q, oidx_q;
  logic [15:0] oval_q;

  logic [4:0] kv_m1;
  logic [3:0] kd_m1, vd_m1;
  logic       in_acc, q_done, slot, j_last, zero_e;
  logic [11:0] r;
  logic signed [19:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [37:0] mul_p;
  logic signed [54:0] sc_full;
  logic signed [26:0] sc_s;
  logic [32:0] rnd_a;
  logic [33:0] rnd_e;
  logic [16:0] e_new;
  logic [39:0] on_num;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign kv_m1 = (kv_len_q == 6'd0) ? 5'd0 :
                 (kv_len_q > 6'(SeqMax)) ? 5'(SeqMax - 1) : 5'(kv_len_q - 6'd1);
  assign kd_m1 = (key_dim_q == 5'd0) ? 4'd0 :
                 (key_dim_q > 5'(KeyDimMax)) ? 4'(KeyDimMax - 1) : 4'(key_dim_q - 5'd1);
  assign vd_m1 = (val_dim_q == 5'd0) ? 4'd0 :
                 (val_dim_q > 5'(ValueDimMax)) ? 4'(ValueDimMax - 1) : 4'(val_dim_q - 5'd1);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc = in_i.valid && in_i.ready;
  assign q_done = in_acc && (in_i.func == FUNC_QUERY) && (in_i.col == kd_m1);
  assign slot   = !ovalid_q || out_o.ready;
  assign j_last = (j_q == kv_m1);

  assign zero_e = d_q >= 28'd49152;
  assign r      = {d_q[7:0], 4'b0000};

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DOT_MAC: begin mul_a = 20'(qv_q); mul_b = 18'(kd_q); end
      S_SC_LO:   begin mul_a = {3'b000, acc_q[16:0]}; mul_b = {2'b00, scale_q}; end
      S_SC_HI:   begin mul_a = 20'($signed(acc_q[35:17])); mul_b = {2'b00, scale_q}; end
      S_EXP_RR:  begin mul_a = {8'b0, r}; mul_b = {6'b0, r}; end
      S_EXP_A:   begin
        mul_a = {3'b000, exp_int(d_q[15:12])};
        mul_b = {1'b0, exp_frac(d_q[11:8])};
      end
      S_EXP_P:   begin mul_a = {3'b000, a_q}; mul_b = {1'b0, p_q}; end
      S_O_MAC:   begin mul_a = 20'(vd_q); mul_b = {1'b0, e_q[j_q]}; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = 38'(mul_a) * 38'(mul_b);

  assign sc_full = (55'(mul_p) <<< 17) + 55'($signed({1'b0, lo_q})) + 55'(28'h8000000);
  assign sc_s    = sc_full[54:28] + (mask_en_q ? 27'(mask_q[j_q]) : 27'sd0);
  assign rnd_a   = mul_p[32:0] + 33'd32768;
  assign rnd_e   = mul_p[33:0] + 34'd32768;
  assign e_new   = zero_e ? 17'd0 : rnd_e[32:16];
  assign on_num  = 40'(acc_q) + 40'(den_q[21:1]);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = den_q;
    case (state_q)
      S_W_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = 40'({e_q[j_q], 15'b0}) + 40'(den_q[21:1]);
      end
      S_O_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = on_num[39] ? ~on_num : on_num;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  sdpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.func == FUNC_KEY) key_mem[{in_i.row, in_i.col}] <= in_i.in_value;
    if (state_q == S_DOT_RD) kd_q <= key_mem[{j_q, t_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.func == FUNC_VALUE) val_mem[{in_i.row, in_i.col}] <= in_i.in_value;
    if (state_q == S_O_RD) vd_q <= val_mem[{j_q, t_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.func == FUNC_MASK)  mask_q[in_i.row] <= in_i.in_value;
    if (in_acc && in_i.func == FUNC_QUERY) qbuf_q[in_i.col] <= in_i.in_value;
    if (state_q == S_SC_HI) score_q[j_q] <= sc_s;
    if (state_q == S_EXP_P) e_q[j_q] <= e_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kv_len_q  <= 6'd32;
      key_dim_q <= 5'd16;
      val_dim_q <= 5'd16;
      scale_q   <= 16'd16384;
      mask_en_q <= 1'b0;
      w_en_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      okind_q   <= 1'b0;
      olast_q   <= 1'b0;
      oqi_q     <= '0;
      oidx_q    <= '0;
      oval_q    <= '0;
      j_q       <= '0;
      t_q       <= '0;
      qi_q      <= '0;
      qv_q      <= '0;
      acc_q     <= '0;
      lo_q      <= '0;
      mx_q      <= '0;
      d_q       <= '0;
      p_q       <= '0;
      a_q       <= '0;
      den_q     <= '0;
      neg_q     <= 1'b0;
      quo_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_KV_LENGTH: kv_len_q  <= cfg_i.data[5:0];
          CFG_KEY_DIM:   key_dim_q <= cfg_i.data[4:0];
          CFG_VALUE_DIM: val_dim_q <= cfg_i.data[4:0];
          CFG_SCALE:     scale_q   <= cfg_i.data;
          CFG_MASK_EN:   mask_en_q <= cfg_i.data[0];
          CFG_WEIGHT_EN: w_en_q    <= cfg_i.data[0];
          default:       ;
        endcase
      end
      if (ovalid_q && out_o.ready && !(state_q inside {S_W_EMIT, S_O_EMIT}))
        ovalid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (q_done) begin
            qi_q    <= in_i.row;
            j_q     <= '0;
            t_q     <= '0;
            acc_q   <= '0;
            state_q <= S_DOT_RD;
          end
        end
        S_DOT_RD: begin
          qv_q    <= qbuf_q[t_q];
          state_q <= S_DOT_MAC;
        end
        S_DOT_MAC: begin
          acc_q <= acc_q + 40'(mul_p);
          if (t_q == kd_m1) begin
            state_q <= S_SC_LO;
          end else begin
            t_q     <= t_q + 4'd1;
            state_q <= S_DOT_RD;
          end
        end
        S_SC_LO: begin
          lo_q    <= mul_p[33:0];
          state_q <= S_SC_HI;
        end
        S_SC_HI: begin
          if (j_q == 5'd0 || sc_s > mx_q) mx_q <= sc_s;
          t_q   <= '0;
          acc_q <= '0;
          if (j_last) begin
            j_q     <= '0;
            den_q   <= '0;
            state_q <= S_EXP_D;
          end else begin
            j_q     <= j_q + 5'd1;
            state_q <= S_DOT_RD;
          end
        end
        S_EXP_D: begin
          d_q     <= 28'(28'(mx_q) - 28'(score_q[j_q]));
          state_q <= S_EXP_RR;
        end
        S_EXP_RR: begin
          p_q     <= 17'h10000 - {5'b0, r} + {10'b0, mul_p[23:17]};
          state_q <= S_EXP_A;
        end
        S_EXP_A: begin
          a_q     <= rnd_a[32:16];
          state_q <= S_EXP_P;
        end
        S_EXP_P: begin
          den_q <= den_q + {5'b0, e_new};
          if (j_last) begin
            j_q     <= '0;
            t_q     <= '0;
            acc_q   <= '0;
            state_q <= w_en_q ? S_W_DIV : S_O_RD;
          end else begin
            j_q     <= j_q + 5'd1;
            state_q <= S_EXP_D;
          end
        end
        S_W_DIV: state_q <= S_W_WAIT;
        S_W_WAIT: begin
          if (div_rsp.done) begin
            quo_q   <= div_rsp.quo;
            state_q <= S_W_EMIT;
          end
        end
        S_W_EMIT: begin
          if (slot) begin
            ovalid_q <= 1'b1;
            okind_q  <= KIND_WEIGHT;
            olast_q  <= 1'b0;
            oqi_q    <= qi_q;
            oidx_q   <= j_q;
            oval_q   <= (quo_q > 40'd32767) ? 16'd32767 : quo_q[15:0];
            if (j_last) begin
              j_q     <= '0;
              state_q <= S_O_RD;
            end else begin
              j_q     <= j_q + 5'd1;
              state_q <= S_W_DIV;
            end
          end
        end
        S_O_RD: state_q <= S_O_MAC;
        S_O_MAC: begin
          acc_q <= acc_q + 40'(mul_p);
          if (j_last) begin
            state_q <= S_O_DIV;
          end else begin
            j_q     <= j_q + 5'd1;
            state_q <= S_O_RD;
          end
        end
        S_O_DIV: begin
          neg_q   <= on_num[39];
          state_q <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (div_rsp.done) begin
            quo_q   <= neg_q ? ~div_rsp.quo : div_rsp.quo;
            state_q <= S_O_EMIT;
          end
        end
        S_O_EMIT: begin
          if (slot) begin
            ovalid_q <= 1'b1;
            okind_q  <= KIND_OUT;
            olast_q  <= (t_q == vd_m1);
            oqi_q    <= qi_q;
            oidx_q   <= {1'b0, t_q};
            if ($signed(quo_q) > 40'sd32767)       oval_q <= 16'h7FFF;
            else if ($signed(quo_q) < -40'sd32768) oval_q <= 16'h8000;
            else                                   oval_q <= quo_q[15:0];
            j_q   <= '0;
            acc_q <= '0;
            if (t_q == vd_m1) begin
              state_q <= S_IDLE;
            end else begin
              t_q     <= t_q + 4'd1;
              state_q <= S_O_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.kind        = okind_q;
  assign out_o.query_index = oqi_q;
  assign out_o.out_index   = oidx_q;
  assign out_o.out_value   = oval_q;
  assign out_o.last        = olast_q;

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
  a_last_is_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> (okind_q == KIND_OUT)) else $error("last on a weight word");
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_done |=> (state_q == S_DOT_RD)) else $error("completed query not started");
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready) |=> $stable(oval_q)) else $error("result overwritten");

endmodule
`default_nettype wire

[rtl/core/sdpa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sdpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdpa_div
  import sdpa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   sh;
  logic            ge;

  assign sh = {rem_q, quo_q[NumW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rem_q  <= '0;
        den_q  <= req_i.den;
        quo_q  <= req_i.num;
        cnt_q  <= 6'(NumW);
      end else if (busy_q) begin
        rem_q <= ge ? DenW'(sh - {1'b0, den_q}) : DenW'(sh);
        quo_q <= {quo_q[NumW-2:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && !busy_q) |=> (busy_q && cnt_q == 6'(NumW)))
    else $error("divider start lost");
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 6'd0)) else $error("divider count ran out");

endmodule
`default_nettype wire
